// ===== hw/rtl/wmxh_pkg.sv =====
package wmxh_pkg;

  // Field widths of one chunk transfer
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned HASH_W  = 64;

  // Packed slave tdata: chunk_data, chunk_bytes, total_length, zero fill to whole bytes
  localparam int unsigned S_TDATA_W = ((DATA_W + COUNT_W + LEN_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((HASH_W + 7) / 8) * 8;

  // Seeds loaded on the first chunk of a message
  localparam logic [63:0] HASH_SEED = 64'd100253314709;
  localparam logic [63:0] MULT_SEED = 64'd179426173;

  // Full chunk byte count
  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

endpackage

// ===== hw/rtl/word_multiply_xor_hash_unit.sv =====
// Word multiply-xor hash unit.
//
// Input stream (s_*): one transfer per 64-bit message chunk, byte zero in the
// lowest bits. s_tuser marks the first chunk of a message (it loads the seeds
// and the tail pad from total_length), s_tlast marks the final chunk. Chunks
// with fewer than eight valid bytes take their upper bytes from the tail pad.
// Output stream (m_*): one transfer per message carrying the 64-bit hash,
// produced only by a chunk with s_tlast set.
//
// Throughput: one chunk per cycle while not stalled. The only loop is the running
// multiplier update (64 by 8 multiply); the 64 by 64 chunk product is split
// into 32-bit partial products over two stages and folded into the hash by
// xor, which is order-free, so it does not limit the rate.
// A last chunk passes the input, word, product and output registers to m_tdata.
//
// Reset loads the reset seeds, clears the tail pad and empties the pipeline.
// When the receiver stalls, a waiting result holds in the output register
// while chunks that give no result keep flowing; the stages behind a held
// last chunk fill up before s_tready drops.
module word_multiply_xor_hash_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // chunk_data [63:0], chunk_bytes [67:64], total_length [99:68], zero [103:100]
  input  logic [wmxh_pkg::S_TDATA_W-1:0]  s_tdata,
  // first_chunk [0]
  input  logic                            s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // hash_value [63:0]
  output logic [wmxh_pkg::M_TDATA_W-1:0]  m_tdata
);

  localparam int unsigned DW = wmxh_pkg::DATA_W;
  localparam int unsigned CW = wmxh_pkg::COUNT_W;
  localparam int unsigned LW = wmxh_pkg::LEN_W;

  // Input register stage
  logic          v0;
  logic [DW-1:0] data0;
  logic [CW-1:0] count0;
  logic [LW-1:0] len0;
  logic          first0, last0;

  // Word and multiplier stage
  logic          v1;
  logic [63:0]   word1, mult1;
  logic          first1, last1;

  // Partial product stage
  logic          v2;
  logic [63:0]   pp_ll2;
  logic [31:0]   pp_lh2, pp_hl2;
  logic          first2, last2;

  // Running state
  logic [63:0]   mult, pad, acc;
  logic [63:0]   out_hash;

  // Stage handshakes
  logic          ready1, ready2;
  logic          mv0, mv1, mv2, take_in;

  assign mv2     = v2 && (!last2 || !m_tvalid || m_tready);
  assign ready2  = !v2 || mv2;
  assign mv1     = v1 && ready2;
  assign ready1  = !v1 || ready2;
  assign mv0     = v0 && ready1;
  assign s_tready = !v0 || ready1;
  assign take_in = s_tvalid && s_tready;

  // Chunk word, multiplier and pad for the chunk in the input register
  logic [63:0]   mult_cur, pad_cur, word_cur, mult_step;
  logic [CW-1:0] count_sat;

  always_comb begin
    count_sat = (count0 > wmxh_pkg::FULL_COUNT) ? wmxh_pkg::FULL_COUNT : count0;
    mult_cur  = first0 ? wmxh_pkg::MULT_SEED : mult;
    pad_cur   = first0 ? (wmxh_pkg::HASH_SEED ^ {{(64-LW){1'b0}}, len0}) : pad;
    for (int i = 0; i < 8; i++) begin
      word_cur[8*i +: 8] = (CW'(i) < count_sat) ? data0[8*i +: 8] : pad_cur[8*i +: 8];
    end
    // Empty chunk has no first byte: keep the multiplier
    if (count_sat == '0) begin
      mult_step = mult_cur;
    end else begin
      mult_step = mult_cur * {56'd0, data0[7:0]};
    end
  end

  // Fold the split product into the hash
  logic [63:0] prod2, acc_base, acc_next;

  always_comb begin
    prod2    = pp_ll2 + {pp_lh2 + pp_hl2, 32'd0};
    acc_base = first2 ? wmxh_pkg::HASH_SEED : acc;
    acc_next = acc_base ^ prod2;
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
      mult     <= wmxh_pkg::MULT_SEED;
      pad      <= '0;
      acc      <= wmxh_pkg::HASH_SEED;
    end else begin
      if (take_in) begin
        v0 <= 1'b1;
      end else if (mv0) begin
        v0 <= 1'b0;
      end
      if (mv0) begin
        v1   <= 1'b1;
        mult <= mult_step;
        pad  <= pad_cur;
      end else if (mv1) begin
        v1 <= 1'b0;
      end
      if (mv1) begin
        v2 <= 1'b1;
      end else if (mv2) begin
        v2 <= 1'b0;
      end
      if (mv2) begin
        acc <= acc_next;
      end
      // Drop a taken result, raise a new one
      if (mv2 && last2) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      data0  <= s_tdata[DW-1:0];
      count0 <= s_tdata[DW +: CW];
      len0   <= s_tdata[DW+CW +: LW];
      first0 <= s_tuser;
      last0  <= s_tlast;
    end
    if (mv0) begin
      word1  <= word_cur;
      mult1  <= mult_cur;
      first1 <= first0;
      last1  <= last0;
    end
    if (mv1) begin
      pp_ll2 <= word1[31:0] * mult1[31:0];
      pp_lh2 <= 32'(word1[31:0] * mult1[63:32]);
      pp_hl2 <= 32'(word1[63:32] * mult1[31:0]);
      first2 <= first1;
      last2  <= last1;
    end
    if (mv2 && last2) begin
      out_hash <= acc_next;
    end
  end

  assign m_tdata = {{(wmxh_pkg::M_TDATA_W - wmxh_pkg::HASH_W){1'b0}}, out_hash};

endmodule

// ===== hw/rtl/wmxh_checker.sv =====
module wmxh_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [wmxh_pkg::M_TDATA_W-1:0] m_tdata
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A free or draining output slot lets every stage advance
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled with output free");

  // A result cannot rise until a chunk has come through the pipeline after reset
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    else $error("result too soon after reset");

endmodule

bind word_multiply_xor_hash_unit wmxh_checker u_wmxh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_PER_PHASE = 370;
  localparam int unsigned FILL_W = wmxh_pkg::S_TDATA_W - wmxh_pkg::DATA_W
                                   - wmxh_pkg::COUNT_W - wmxh_pkg::LEN_W;

  // Running multiply-xor hash with its own copy of the state; holds the
  // hashes that are due on the output in order.
  class hash_tracker;
    logic [63:0] run_hash;
    logic [63:0] run_mult;
    logic [63:0] pad_word;
    logic [63:0] pending_hashes[$];
    int unsigned mismatches;
    int unsigned chunks_seen;
    int unsigned hashes_checked;

    function new();
      run_hash = wmxh_pkg::HASH_SEED;
      run_mult = wmxh_pkg::MULT_SEED;
      pad_word = '0;
      mismatches = 0;
      chunks_seen = 0;
      hashes_checked = 0;
    endfunction

    // Fold one accepted chunk into the running hash
    function void absorb_chunk(logic [63:0] data, logic [3:0] nbytes, logic [31:0] len,
                               logic first, logic last);
      logic [63:0] word;
      logic [63:0] keep;
      int unsigned used;
      used = 32'((nbytes > wmxh_pkg::FULL_COUNT) ? wmxh_pkg::FULL_COUNT : nbytes);
      if (first) begin
        run_hash = wmxh_pkg::HASH_SEED;
        run_mult = wmxh_pkg::MULT_SEED;
        pad_word = wmxh_pkg::HASH_SEED ^ {32'd0, len};
      end
      // Short chunks take their upper bytes from the pad, empty ones all of it
      if (used == wmxh_pkg::FULL_COUNT) begin
        word = data;
      end else if (used == 0) begin
        word = pad_word;
      end else begin
        keep = (64'd1 << (8 * used)) - 64'd1;
        word = (data & keep) | (pad_word & ~keep);
      end
      run_hash = run_hash ^ (word * run_mult);
      if (used != 0) run_mult = run_mult * {56'd0, data[7:0]};
      if (last) pending_hashes.push_back(run_hash);
      chunks_seen++;
    endfunction

    // Compare one output transfer with the oldest hash due
    function void compare_hash(logic [63:0] got);
      logic [63:0] want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash transfer with none due: actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked++;
        if (got !== want) begin
          $display("%0t: hash_value mismatch: expected %h actual %h", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [wmxh_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [wmxh_pkg::M_TDATA_W-1:0] m_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned idle_cycles = 0;
  hash_tracker tracker = new();

  word_multiply_xor_hash_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Randomly stall the hash receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted hash
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.compare_hash(m_tdata[wmxh_pkg::HASH_W-1:0]);
  end

  // Abort when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one chunk, with random idle cycles ahead, and hold it until taken
  task automatic send_chunk(logic [63:0] data, logic [3:0] nbytes, logic [31:0] len,
                            logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{FILL_W{1'b0}}, len, nbytes, data};
    s_tuser <= first;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    tracker.absorb_chunk(data, nbytes, len, first, last);
  endtask

  // Well-formed message with random content, or a single chunk of noise
  task automatic send_random_message(inout int unsigned sent);
    logic [63:0] data;
    int unsigned len;
    int unsigned nchunks;
    int unsigned tail;
    if ($urandom_range(99) < 80) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
      nchunks = (len == 0) ? 1 : (len + 7) / 8;
      for (int unsigned k = 0; k < nchunks; k++) begin
        data = {$urandom, $urandom};
        if ($urandom_range(7) == 0) data[7:0] = 8'd0;
        tail = (len == 0) ? 0 : len - 8 * k;
        send_chunk(data, (k == nchunks - 1) ? tail[3:0] : wmxh_pkg::FULL_COUNT,
                   (k == 0) ? len : $urandom, k == 0, k == nchunks - 1);
        sent++;
      end
    end else begin
      send_chunk({$urandom, $urandom}, 4'($urandom_range(15)), $urandom,
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      sent++;
    end
  endtask

  task automatic wait_for_hashes();
    while (tracker.pending_hashes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state without a first chunk
    send_chunk(64'h0123_4567_89ab_cdef, wmxh_pkg::FULL_COUNT, 32'd0, 1'b0, 1'b1);
    send_chunk(64'hffff_ffff_ff12_3456, 4'd3, 32'd77, 1'b0, 1'b1);
    // Empty message: all pad, data ignored
    send_chunk('1, 4'd0, 32'd0, 1'b1, 1'b1);
    send_chunk('1, wmxh_pkg::FULL_COUNT, 32'd8, 1'b1, 1'b1);
    send_chunk('0, wmxh_pkg::FULL_COUNT, 32'd8, 1'b1, 1'b1);
    // Short single-chunk messages, upper data bytes ignored
    for (int unsigned n = 1; n < wmxh_pkg::FULL_COUNT; n++) begin
      send_chunk('1, n[3:0], n, 1'b1, 1'b1);
    end
    // Oversized byte counts act as full chunks
    send_chunk(64'h8000_0000_0000_0001, 4'd15, 32'hffff_ffff, 1'b1, 1'b1);
    send_chunk(64'h5a5a_a5a5_0f0f_f0f0, 4'd9, 32'haaaa_aaaa, 1'b1, 1'b1);
    // Three-chunk message with a zero first byte mid-way
    send_chunk(64'hdead_beef_cafe_f00d, wmxh_pkg::FULL_COUNT, 32'd20, 1'b1, 1'b0);
    send_chunk(64'h1122_3344_5566_7700, wmxh_pkg::FULL_COUNT, 32'h5555_5555, 1'b0, 1'b0);
    send_chunk(64'h9999_9999_8877_6655, 4'd4, 32'd0, 1'b0, 1'b1);
    // Continue after a last chunk without a new first
    send_chunk(64'h0f1e_2d3c_4b5a_6978, wmxh_pkg::FULL_COUNT, 32'd3, 1'b0, 1'b1);
    // Empty chunk inside a message keeps the multiplier
    send_chunk(64'h7777_0000_1234_00ff, wmxh_pkg::FULL_COUNT, 32'h5555_5555, 1'b1, 1'b0);
    send_chunk(64'h0000_0000_0000_0033, 4'd0, 32'd0, 1'b0, 1'b1);
    send_chunk(64'hfedc_ba98_7654_3210, 4'd2, 32'haaaa_aaaa, 1'b1, 1'b1);

    // Random: three idle profiles, pausing the sender until all hashes are in
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 83 : 0;
      recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 10 : 0;
      sent = 0;
      while (sent < RANDOM_PER_PHASE) send_random_message(sent);
      s_tvalid <= 1'b0;
      wait_for_hashes();
      @(posedge clk);
    end

    wait_for_hashes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d chunks (directed edge cases, then random messages and noise)",
             tracker.chunks_seen);
    $display("under three stall profiles; %0d hashes checked, %0d mismatches",
             tracker.hashes_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_hashes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
